>>> rtl/skyline_rect_packer_defines.svh
// Assertion helpers for the skyline packer
`ifndef SKYLINE_RECT_PACKER_DEFINES_SVH
`define SKYLINE_RECT_PACKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/srp_pkg.sv
package srp_pkg;

  // fixed field widths
  localparam int SIZE_BITS = 13;
  localparam int OUT_BITS  = 12;

  // defaults for the top-level parameters
  localparam int DEF_MAX_SEGMENTS = 256;
  localparam int DEF_COORD_BITS   = 13;

  // atlas size after reset
  localparam int ATLAS_RESET = 512;

  // register index codes (address bit 2)
  localparam logic CFG_ATLAS_WIDTH  = 1'b0;
  localparam logic CFG_ATLAS_HEIGHT = 1'b1;

  // controller to datapath strobes
  typedef struct packed {
    logic init;
    logic load_req;
    logic clr;
    logic rd_i;
    logic chk_i;
    logic rd_j;
    logic chk_j;
    logic next_i;
    logic up_begin;
    logic emit_n;
    logic rd_k;
    logic use_k;
    logic flush;
    logic load_out;
  } srp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic x_fail;
    logic y_fail;
    logic zero_w;
    logic j_end;
    logic left_pos;
    logic last_i;
    logic found;
    logic k_best;
    logic k_end;
    logic ins_done;
    logic full;
  } srp_stat_t;

endpackage

>>> rtl/srp_ctrl.sv
module srp_ctrl import srp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      req_type,
  output logic      out_valid,
  input  logic      out_stall,
  input  srp_stat_t st,
  output srp_cmd_t  cmd
);

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CLR      = 4'd2;
  localparam logic [3:0] S_FIT_RD   = 4'd3;
  localparam logic [3:0] S_FIT_CHK  = 4'd4;
  localparam logic [3:0] S_WALK_RD  = 4'd5;
  localparam logic [3:0] S_WALK_CHK = 4'd6;
  localparam logic [3:0] S_NEXT     = 4'd7;
  localparam logic [3:0] S_FIT_END  = 4'd8;
  localparam logic [3:0] S_UP_RD    = 4'd9;
  localparam logic [3:0] S_UP_USE   = 4'd10;
  localparam logic [3:0] S_FLUSH    = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  logic [3:0] state, state_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE);

  // sequencing
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          if (req_type)     state_next = S_CLR;
          else if (st.full) state_next = S_DONE;
          else              state_next = S_FIT_RD;
        end
      end
      S_CLR: begin
        cmd.clr    = 1'b1;
        state_next = S_DONE;
      end
      S_FIT_RD: begin
        cmd.rd_i   = 1'b1;
        state_next = S_FIT_CHK;
      end
      S_FIT_CHK: begin
        cmd.chk_i = 1'b1;
        if (st.x_fail || st.zero_w) state_next = S_NEXT;
        else                        state_next = S_WALK_RD;
      end
      S_WALK_RD: begin
        cmd.rd_j = 1'b1;
        if (st.j_end) state_next = S_NEXT;
        else          state_next = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        cmd.chk_j = 1'b1;
        if (st.y_fail || !st.left_pos) state_next = S_NEXT;
        else                           state_next = S_WALK_RD;
      end
      S_NEXT: begin
        cmd.next_i = 1'b1;
        if (st.last_i) state_next = S_FIT_END;
        else           state_next = S_FIT_RD;
      end
      S_FIT_END: begin
        if (st.found) begin
          cmd.up_begin = 1'b1;
          state_next   = S_UP_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_UP_RD: begin
        if (st.k_best && !st.ins_done) begin
          cmd.emit_n = 1'b1;
        end else if (st.k_end) begin
          state_next = S_FLUSH;
        end else begin
          cmd.rd_k   = 1'b1;
          state_next = S_UP_USE;
        end
      end
      S_UP_USE: begin
        cmd.use_k  = 1'b1;
        state_next = S_UP_RD;
      end
      S_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!(out_valid && out_stall)) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  // output word pending flag
  assign out_valid_next = cmd.load_out || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/srp_dp.sv
module srp_dp import srp_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int COORD_BITS   = DEF_COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SIZE_BITS-1:0] aw,
  input  logic [SIZE_BITS-1:0] ah,
  input  logic                 req_type,
  input  logic [SIZE_BITS-1:0] rect_width,
  input  logic [SIZE_BITS-1:0] rect_height,
  input  srp_cmd_t             cmd,
  output srp_stat_t            st,
  output logic                 granted,
  output logic [OUT_BITS-1:0]  place_x,
  output logic [OUT_BITS-1:0]  place_y
);

  localparam int CW = COORD_BITS;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int NW = $clog2(MAX_SEGMENTS + 1);
  localparam int AW = ((CW > SIZE_BITS) ? CW : SIZE_BITS) + 3;
  localparam int SW = 3 * CW;

  // segment store: {x, y, w}
  logic [SW-1:0] mem [MAX_SEGMENTS];
  logic [SW-1:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic          we;
  logic [IW-1:0] wa;
  logic [SW-1:0] wd;

  logic [NW-1:0]        count, i, j, k, wcnt, best;
  logic [CW-1:0]        top, cur_x, cur_w, bx, by;
  logic signed [AW-1:0] left;
  logic [AW-1:0]        best_h, best_w;
  logic                 cand_ok, found, is_clr, pend_v, ins_done, shrinking;
  logic [SIZE_BITS-1:0] req_w, req_h;
  logic [SW-1:0]        pend;

  logic [CW-1:0]        rx, ry, rw, px, py, pw, nx, ny, nw;
  logic [AW-1:0]        rx_e, ry_e, rw_e, wq_e, hq_e, aw_e, ah_e, th;
  logic signed [AW-1:0] left_next;
  logic                 better;
  logic [CW:0]          end_e, sx_e, cut;
  logic                 e_v, shrink_stop;
  logic [SW-1:0]        e_seg;

  assign rx = rd_data[SW-1 -: CW];
  assign ry = rd_data[2*CW-1 -: CW];
  assign rw = rd_data[CW-1:0];
  assign px = pend[SW-1 -: CW];
  assign py = pend[2*CW-1 -: CW];
  assign pw = pend[CW-1:0];

  assign rx_e = AW'(rx);
  assign ry_e = AW'(ry);
  assign rw_e = AW'(rw);
  assign wq_e = AW'(req_w);
  assign hq_e = AW'(req_h);
  assign aw_e = AW'(aw);
  assign ah_e = AW'(ah);

  // fit tests, one pixel margin
  assign left_next = left - $signed(rw_e);
  assign th        = AW'(top) + hq_e;
  assign better    = cand_ok && ((th < best_h) ||
                     ((th == best_h) && (cur_w != '0) && (AW'(cur_w) < best_w)));

  assign st.x_fail   = (aw == '0) || ((rx_e + wq_e) >= aw_e);
  assign st.y_fail   = (ah == '0) || ((ry_e + hq_e) >= ah_e);
  assign st.zero_w   = (req_w == '0);
  assign st.j_end    = (j >= count);
  assign st.left_pos = (left_next > 0);
  assign st.last_i   = ((i + NW'(1)) >= count);
  assign st.found    = found;
  assign st.k_best   = (k == best);
  assign st.k_end    = (k == count);
  assign st.ins_done = ins_done;
  assign st.full     = (count >= NW'(MAX_SEGMENTS));

  // new segment and the span it covers
  assign nx    = bx;
  assign ny    = CW'(AW'(by) + hq_e);
  assign nw    = CW'(req_w);
  assign end_e = {1'b0, nx} + {1'b0, nw};
  assign sx_e  = {1'b0, rx};
  assign cut   = end_e - sx_e;

  // word offered to the merge stage
  always_comb begin
    e_v         = 1'b0;
    e_seg       = rd_data;
    shrink_stop = 1'b0;
    if (cmd.emit_n) begin
      e_v   = 1'b1;
      e_seg = {nx, ny, nw};
    end else if (cmd.use_k) begin
      if (!ins_done || !shrinking) begin
        e_v = 1'b1;
      end else if (sx_e >= end_e) begin
        e_v         = 1'b1;
        shrink_stop = 1'b1;
      end else if ({1'b0, rw} > cut) begin
        e_v         = 1'b1;
        e_seg       = {end_e[CW-1:0], ry, rw - cut[CW-1:0]};
        shrink_stop = 1'b1;
      end
    end
  end

  // store write port
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = pend;
    if (cmd.init) begin
      we = 1'b1;
      wd = {{(2*CW){1'b0}}, CW'(ATLAS_RESET)};
    end else if (cmd.clr) begin
      we = 1'b1;
      wd = {{(2*CW){1'b0}}, CW'(aw)};
    end else if (cmd.flush) begin
      we = 1'b1;
      wa = wcnt[IW-1:0];
    end else if (e_v && pend_v && (e_seg[2*CW-1 -: CW] != py)) begin
      we = 1'b1;
      wa = wcnt[IW-1:0];
    end
  end

  always_comb begin
    if (cmd.rd_k)      rd_addr = k[IW-1:0];
    else if (cmd.rd_j) rd_addr = j[IW-1:0];
    else               rd_addr = i[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= NW'(1);
      found     <= 1'b0;
      is_clr    <= 1'b0;
      pend_v    <= 1'b0;
      ins_done  <= 1'b0;
      shrinking <= 1'b0;
      cand_ok   <= 1'b0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      wcnt      <= '0;
    end else begin
      if (cmd.init || cmd.clr) count <= NW'(1);
      if (cmd.load_req) begin
        is_clr <= req_type;
        found  <= 1'b0;
        i      <= '0;
      end
      if (cmd.chk_i) begin
        j       <= i;
        cand_ok <= !st.x_fail;
      end
      if (cmd.rd_j && st.j_end) cand_ok <= 1'b0;
      if (cmd.chk_j) begin
        j <= j + NW'(1);
        if (st.y_fail) cand_ok <= 1'b0;
      end
      if (cmd.next_i) begin
        i <= i + NW'(1);
        if (better) found <= 1'b1;
      end
      if (cmd.up_begin) begin
        k         <= '0;
        wcnt      <= '0;
        pend_v    <= 1'b0;
        ins_done  <= 1'b0;
        shrinking <= 1'b1;
      end
      if (cmd.emit_n) ins_done <= 1'b1;
      if (cmd.use_k) begin
        k <= k + NW'(1);
        if (ins_done && shrink_stop) shrinking <= 1'b0;
      end
      if (e_v) begin
        if (!pend_v) pend_v <= 1'b1;
        else if (e_seg[2*CW-1 -: CW] != py) wcnt <= wcnt + NW'(1);
      end
      if (cmd.flush) count <= wcnt + NW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_w  <= rect_width;
      req_h  <= rect_height;
      best_h <= ah_e;
      best_w <= aw_e;
    end
    if (cmd.chk_i) begin
      top   <= ry;
      left  <= $signed(wq_e);
      cur_x <= rx;
      cur_w <= rw;
    end
    if (cmd.chk_j) begin
      if (ry > top) top <= ry;
      left <= left_next;
    end
    if (cmd.next_i && better) begin
      best_h <= th;
      best_w <= AW'(cur_w);
      best   <= i;
      bx     <= cur_x;
      by     <= top;
    end
    // merge neighbours of equal height
    if (e_v) begin
      if (pend_v && (e_seg[2*CW-1 -: CW] == py)) pend <= {px, py, pw + e_seg[CW-1:0]};
      else                                      pend <= e_seg;
    end
    if (cmd.load_out) begin
      granted <= is_clr || found;
      place_x <= (found && !is_clr) ? OUT_BITS'(bx) : '0;
      place_y <= (found && !is_clr) ? OUT_BITS'(by) : '0;
    end
  end

endmodule

>>> rtl/skyline_rect_packer.sv
// Skyline rectangle allocator for a 2D atlas. A reserve word (req_type 0)
// places a rect_width x rect_height rectangle bottom-left on the skyline,
// keeping one pixel of margin at the right and bottom, and returns granted
// with place_x/place_y, or granted 0 with 0,0 when nothing fits or the
// segment store is full. A clear word (req_type 1) resets the skyline to one
// segment of atlas_width and returns granted 1. One word is in flight at a
// time; the segment store has one read port with registered data, so every
// segment visit takes a read state and then a check state. A finished word
// waits while out_stall holds the previous result.
// After atlas_width or atlas_height is written a clear must be issued.
// Registers: atlas_width at 0x0, atlas_height at 0x4, reset 512 each.
`include "skyline_rect_packer_defines.svh"
module skyline_rect_packer import srp_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int COORD_BITS   = DEF_COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic [SIZE_BITS-1:0] rect_width,
  input  logic [SIZE_BITS-1:0] rect_height,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 granted,
  output logic [OUT_BITS-1:0]  place_x,
  output logic [OUT_BITS-1:0]  place_y,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [SIZE_BITS-1:0] atlas_width, atlas_height;
  srp_cmd_t             cmd;
  srp_stat_t            st;

  // size registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width  <= SIZE_BITS'(ATLAS_RESET);
      atlas_height <= SIZE_BITS'(ATLAS_RESET);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        CFG_ATLAS_WIDTH:  atlas_width  <= pwdata[SIZE_BITS-1:0];
        CFG_ATLAS_HEIGHT: atlas_height <= pwdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      CFG_ATLAS_WIDTH:  prdata = 32'(atlas_width);
      CFG_ATLAS_HEIGHT: prdata = 32'(atlas_height);
      default:          prdata = '0;
    endcase
  end

  srp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  srp_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .aw          (atlas_width),
    .ah          (atlas_height),
    .req_type    (req_type),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .cmd         (cmd),
    .st          (st),
    .granted     (granted),
    .place_x     (place_x),
    .place_y     (place_y)
  );

  // checks
  `SRP_ASSERT_IMP(a_fail_zero, out_valid && !granted, (place_x == '0) && (place_y == '0), "refused word carries non-zero place")
  `SRP_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "new word taken while one is in flight")
  `SRP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(place_x) && $stable(place_y) && $stable(granted), "stalled result changed")

endmodule

>>> verif/testbench.sv
`default_nettype none
module testbench;
  import srp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEG = DEF_MAX_SEGMENTS;
  localparam int CYCLE_LIMIT = 20000000;
  localparam logic REQ_RESERVE = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef struct {
    logic               ok;
    logic [OUT_BITS-1:0] x;
    logic [OUT_BITS-1:0] y;
  } placement_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = REQ_RESERVE;
  logic [SIZE_BITS-1:0] rect_width = '0;
  logic [SIZE_BITS-1:0] rect_height = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic granted;
  logic [OUT_BITS-1:0] place_x, place_y;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  skyline_rect_packer dut (.*);

  always #1 clk = ~clk;

  // shadow skyline
  logic [DEF_COORD_BITS-1:0] seg_x[NSEG], seg_y[NSEG], seg_w[NSEG];
  int seg_n;
  int atlas_w = ATLAS_RESET, atlas_h = ATLAS_RESET;

  placement_t pending_q[$];
  int mismatches = 0, cycles = 0;
  int n_words = 0, n_placed = 0, n_refused = 0, n_clears = 0, n_cfg = 0;
  bit sender_idle = 1'b1, receiver_idle = 1'b1;
  int hold_cycles = 0, stall_left = 0;

  function automatic void clear_skyline();
    for (int i = 0; i < NSEG; i++) begin
      seg_x[i] = '0; seg_y[i] = '0; seg_w[i] = '0;
    end
    seg_w[0] = atlas_w[DEF_COORD_BITS-1:0];
    seg_n = 1;
  endfunction

  // top y if the rectangle's left edge sits on segment idx, else -1
  function automatic int fit_top(int idx, int w, int h);
    int top, left;
    if (int'(seg_x[idx]) + w > atlas_w - 1) return -1;
    top = int'(seg_y[idx]);
    left = w;
    while (left > 0) begin
      if (idx >= seg_n) return -1;
      if (int'(seg_y[idx]) > top) top = int'(seg_y[idx]);
      if (int'(seg_y[idx]) + h > atlas_h - 1) return -1;
      left -= int'(seg_w[idx]);
      idx++;
    end
    return top;
  endfunction

  function automatic void drop_segment(int i);
    for (int k = i; k + 1 < seg_n; k++) begin
      seg_x[k] = seg_x[k+1]; seg_y[k] = seg_y[k+1]; seg_w[k] = seg_w[k+1];
    end
    seg_n--;
  endfunction

  function automatic placement_t place_rect(logic clr, int w, int h);
    placement_t r;
    int best_h, best_w, best, bx, by, top, sw, e, cut, i;
    bit found;
    r.ok = 1'b0; r.x = '0; r.y = '0;
    if (clr == REQ_CLEAR) begin
      clear_skyline();
      r.ok = 1'b1;
      return r;
    end
    if (seg_n >= NSEG || seg_n == 0) return r;
    best_h = atlas_h; best_w = atlas_w; best = 0; bx = 0; by = 0; found = 0;
    for (i = 0; i < seg_n; i++) begin
      top = fit_top(i, w, h);
      sw = int'(seg_w[i]);
      if (top < 0) continue;
      if (top + h < best_h || (top + h == best_h && sw > 0 && sw < best_w)) begin
        best_h = top + h; best_w = sw; best = i;
        bx = int'(seg_x[i]); by = top; found = 1;
      end
    end
    if (!found) return r;
    // open a slot for the new segment
    for (i = seg_n; i > best; i--) begin
      seg_x[i] = seg_x[i-1]; seg_y[i] = seg_y[i-1]; seg_w[i] = seg_w[i-1];
    end
    seg_x[best] = DEF_COORD_BITS'(bx);
    seg_y[best] = DEF_COORD_BITS'(by + h);
    seg_w[best] = DEF_COORD_BITS'(w);
    seg_n++;
    // trim whatever the new segment covers
    i = best + 1;
    while (i < seg_n) begin
      e = int'(seg_x[best]) + int'(seg_w[best]);
      if (int'(seg_x[i]) >= e) break;
      cut = e - int'(seg_x[i]);
      seg_x[i] = DEF_COORD_BITS'(int'(seg_x[i]) + cut);
      if (int'(seg_w[i]) > cut) begin
        seg_w[i] = DEF_COORD_BITS'(int'(seg_w[i]) - cut);
        break;
      end
      drop_segment(i);
    end
    // merge level neighbours
    i = 0;
    while (i + 1 < seg_n) begin
      if (seg_y[i] == seg_y[i+1]) begin
        seg_w[i] = seg_w[i] + seg_w[i+1];
        drop_segment(i + 1);
      end else begin
        i++;
      end
    end
    r.ok = 1'b1; r.x = OUT_BITS'(bx); r.y = OUT_BITS'(by);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    placement_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: ok=%0d x=%0d y=%0d",
                                       granted, place_x, place_y);
      end else begin
        e = pending_q.pop_front();
        if (e.ok !== granted || e.x !== place_x || e.y !== place_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ok=%0d x=%0d y=%0d, got ok=%0d x=%0d y=%0d",
                     e.ok, e.x, e.y, granted, place_x, place_y);
        end
      end
    end
  end

  // receiver stalls: long hold on request, else random bursts
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!receiver_idle && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_word(logic kind, int w, int h);
    placement_t r;
    @(negedge clk);
    if (!sender_idle && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    req_type = kind;
    rect_width = w[SIZE_BITS-1:0];
    rect_height = h[SIZE_BITS-1:0];
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    r = place_rect(kind, int'(w[SIZE_BITS-1:0]), int'(h[SIZE_BITS-1:0]));
    pending_q.insert(pending_q.size(), r);
    n_words++;
    if (kind == REQ_CLEAR) n_clears++;
    else if (r.ok) n_placed++;
    else n_refused++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // register write while idle
  task automatic write_reg(logic idx, int value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (idx == CFG_ATLAS_WIDTH) atlas_w = value & 32'h1FFF;
    else atlas_h = value & 32'h1FFF;
    n_cfg++;
  endtask

  task automatic set_atlas(int w, int h, bit do_clear);
    drain();
    write_reg(CFG_ATLAS_WIDTH, w);
    write_reg(CFG_ATLAS_HEIGHT, h);
    if (do_clear) send_word(REQ_CLEAR, 0, 0);
  endtask

  // field extremes, margins, zero sizes, clear
  task automatic test_directed();
    send_word(REQ_RESERVE, 1, 1);
    send_word(REQ_RESERVE, 510, 1);
    send_word(REQ_RESERVE, 511, 1);
    send_word(REQ_RESERVE, 8191, 8191);
    send_word(REQ_RESERVE, 4096, 1);
    send_word(REQ_RESERVE, 0, 5);
    send_word(REQ_RESERVE, 7, 0);
    send_word(REQ_RESERVE, 0, 0);
    send_word(REQ_RESERVE, 20, 400);
    send_word(REQ_RESERVE, 20, 109);
    send_word(REQ_RESERVE, 20, 110);
    send_word(REQ_RESERVE, 5, 3);
    send_word(REQ_RESERVE, 5, 3);
    send_word(REQ_CLEAR, 8191, 8191);
    send_word(REQ_RESERVE, 100, 510);
    send_word(REQ_RESERVE, 100, 511);
    send_word(REQ_CLEAR, 0, 0);
  endtask

  // register extremes, and a size change without a clear
  task automatic test_atlas_sizes();
    set_atlas(0, 0, 1);
    send_word(REQ_RESERVE, 0, 0);
    send_word(REQ_RESERVE, 1, 1);
    set_atlas(1, 1, 1);
    send_word(REQ_RESERVE, 0, 0);
    send_word(REQ_RESERVE, 1, 1);
    set_atlas(8191, 8191, 1);
    send_word(REQ_RESERVE, 4096, 4096);
    send_word(REQ_RESERVE, 8000, 100);
    set_atlas(4096, 4096, 1);
    send_word(REQ_RESERVE, 300, 10);
    set_atlas(64, 64, 0);
    send_word(REQ_RESERVE, 40, 4);
    send_word(REQ_RESERVE, 3, 3);
    set_atlas(8000, 8000, 0);
    send_word(REQ_RESERVE, 5000, 4);
    send_word(REQ_CLEAR, 0, 0);
    send_word(REQ_RESERVE, 5000, 4);
  endtask

  // fill the segment store: unit-wide columns of alternating height
  task automatic test_store_full();
    set_atlas(4096, 4096, 1);
    for (int i = 0; i < NSEG - 1; i++) send_word(REQ_RESERVE, 1, 1 + (i % 2));
    send_word(REQ_RESERVE, 1, 1);
    send_word(REQ_RESERVE, 3, 9);
    send_word(REQ_CLEAR, 0, 0);
  endtask

  task automatic random_reserve();
    int w, h;
    case ($urandom_range(0, 19))
      0: begin w = $urandom_range(0, 8191); h = $urandom_range(0, 8191); end
      1: begin w = 0; h = $urandom_range(0, 64); end
      2: begin w = atlas_w - 1 - $urandom_range(0, 1); h = $urandom_range(1, 8); end
      default: begin
        w = $urandom_range(1, atlas_w / 4 + 1);
        h = $urandom_range(1, atlas_h / 6 + 1);
      end
    endcase
    if (w < 0) w = 0;
    send_word(REQ_RESERVE, w, h);
  endtask

  // sessions: maybe resize, clear, then a run of reserves
  task automatic test_random(int words);
    int stop, aw, ah;
    stop = n_words + words;
    while (n_words < stop) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0: begin aw = $urandom_range(0, 8191); ah = $urandom_range(0, 8191); end
          1: begin aw = $urandom_range(1, 16); ah = $urandom_range(1, 16); end
          default: begin aw = $urandom_range(32, 1024); ah = $urandom_range(32, 1024); end
        endcase
        set_atlas(aw, ah, $urandom_range(0, 7) != 0);
      end else begin
        send_word(REQ_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 8191));
      end
      repeat ($urandom_range(10, 50)) begin
        if ($urandom_range(0, 40) == 0) send_word(REQ_CLEAR, 0, 0);
        else random_reserve();
      end
    end
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    set_atlas(512, 512, 1);
    hold_cycles = 3000;
    repeat (30) random_reserve();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    clear_skyline();
    test_directed();
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    test_atlas_sizes();
    test_store_full();
    test_backpressure();
    test_random(1400);
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    test_random(250);
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d words: %0d placed, %0d refused, %0d clears, %0d register writes",
             n_words, n_placed, n_refused, n_clears, n_cfg);
    $display("store-full refusal, zero sizes, size change without clear, long output hold");
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d words outstanding", mismatches, pending_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
